[src/i2cmbs_pkg.sv]
`timescale 1ns / 1ps

package i2cmbs_pkg;

  // Command codes carried on the action field
  localparam logic [2:0] CMD_IDLE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_RECV  = 3'd4;
  localparam logic [2:0] CMD_WACK  = 3'd5;
  localparam logic [2:0] CMD_SACK  = 3'd6;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd11;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // One input word as held in the input register
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // One result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

[src/i2cmbs_core.sv]
`timescale 1ns / 1ps

module i2cmbs_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  i2cmbs_pkg::item_t  item,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output i2cmbs_pkg::result_t result
);
  import i2cmbs_pkg::*;

  // Sequencer state
  logic [7:0] phase_ticks;
  logic [2:0] command_reg;
  logic [1:0] phase_index;
  logic [3:0] bit_count;
  logic [7:0] shift_reg;
  logic [7:0] delay_count;
  logic       scl_reg;
  logic       sda_reg;
  logic       ack_reg;
  logic       ack_drive;
  logic [7:0] rx_hold;

  logic [2:0] command_reg_next;
  logic [1:0] phase_index_next;
  logic [3:0] bit_count_next;
  logic [7:0] shift_reg_next;
  logic [7:0] delay_count_next;
  logic       scl_reg_next;
  logic       sda_reg_next;
  logic       ack_reg_next;
  logic       ack_drive_next;
  logic [7:0] rx_hold_next;
  logic       done;
  logic       rej;
  logic [7:0] ticks;
  logic       is_cmd;

  // Line levels on entry to a phase, {scl, sda}
  function automatic logic [1:0] enter_lines(input logic [2:0] cmd, input logic [1:0] p,
                                             input logic msb, input logic ackd,
                                             input logic scl, input logic sda);
    logic [1:0] lines;
    lines = {scl, sda};
    unique case (cmd)
      CMD_START: lines = (p == 2'd0) ? 2'b11 : {scl, 1'b0};
      CMD_STOP:  lines = (p == 2'd0) ? 2'b10 : {scl, 1'b1};
      CMD_SEND: begin
        if (p == 2'd0)      lines = {1'b0, sda};
        else if (p == 2'd1) lines = {scl, msb};
        else                lines = {1'b1, sda};
      end
      CMD_RECV:  lines = {(p == 2'd0), sda};
      CMD_WACK:  lines = (p == 2'd0) ? 2'b11 : {1'b0, sda};
      CMD_SACK: begin
        if (p == 2'd0)      lines = {1'b0, ackd};
        else if (p == 2'd1) lines = {1'b1, sda};
        else                lines = 2'b01;
      end
      default:   lines = {scl, sda};
    endcase
    return lines;
  endfunction

  assign ticks  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign is_cmd = (item.action >= CMD_START) && (item.action <= CMD_SACK);

  // One tick of the sequencer
  always_comb begin
    logic [1:0] last;
    logic       fin;
    command_reg_next = command_reg;
    phase_index_next = phase_index;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    ack_reg_next     = ack_reg;
    ack_drive_next   = ack_drive;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    rej              = 1'b0;
    last             = ((command_reg == CMD_SEND) || (command_reg == CMD_SACK)) ? 2'd2 : 2'd1;
    fin              = 1'b0;

    if (command_reg != CMD_IDLE) begin
      rej              = is_cmd;
      delay_count_next = delay_count - 8'd1;
      if (delay_count_next == 8'd0) begin
        // end of phase: take samples first
        if (command_reg == CMD_RECV && phase_index == 2'd0)
          shift_reg_next = {shift_reg[6:0], item.sda_in};
        if (command_reg == CMD_WACK && phase_index == 2'd0)
          ack_reg_next = item.sda_in;

        if (phase_index < last) begin
          phase_index_next = phase_index + 2'd1;
          {scl_reg_next, sda_reg_next} = enter_lines(command_reg, phase_index_next,
                                                     shift_reg_next[7], ack_drive,
                                                     scl_reg, sda_reg);
          delay_count_next = ticks;
        end else begin
          fin = 1'b1;
          if (command_reg == CMD_SEND || command_reg == CMD_RECV) begin
            if (command_reg == CMD_SEND)
              shift_reg_next = {shift_reg_next[6:0], 1'b0};
            bit_count_next = bit_count + 4'd1;
            if (bit_count_next < BITS_PER_BYTE) begin
              phase_index_next = 2'd0;
              {scl_reg_next, sda_reg_next} = enter_lines(command_reg, 2'd0,
                                                         shift_reg_next[7], ack_drive,
                                                         scl_reg, sda_reg);
              delay_count_next = ticks;
              fin = 1'b0;
            end
          end
          if (fin) begin
            if (command_reg == CMD_START || command_reg == CMD_SEND)
              scl_reg_next = 1'b0;
            if (command_reg == CMD_RECV)
              rx_hold_next = shift_reg_next;
            command_reg_next = CMD_IDLE;
            phase_index_next = 2'd0;
            bit_count_next   = 4'd0;
            delay_count_next = 8'd0;
            done             = 1'b1;
          end
        end
      end
    end else if (is_cmd) begin
      // idle: launch a new command
      command_reg_next = item.action;
      phase_index_next = 2'd0;
      bit_count_next   = 4'd0;
      if (item.action == CMD_SEND)
        shift_reg_next = item.tx_byte;
      if (item.action == CMD_RECV) begin
        shift_reg_next = 8'd0;
        sda_reg_next   = 1'b1;
      end
      if (item.action == CMD_SACK)
        ack_drive_next = item.ack_level;
      {scl_reg_next, sda_reg_next} = enter_lines(item.action, 2'd0, shift_reg_next[7],
                                                 ack_drive_next, scl_reg_next,
                                                 sda_reg_next);
      delay_count_next = ticks;
    end
  end

  // Result word for this tick
  always_comb begin
    result.scl_level = scl_reg_next;
    result.sda_level = sda_reg_next;
    result.busy_res  = (command_reg_next != CMD_IDLE);
    result.done_res  = done;
    result.rx_byte   = rx_hold_next;
    result.ack_seen  = ack_reg_next;
    result.rejected  = rej;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
      command_reg <= CMD_IDLE;
      phase_index <= 2'd0;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_reg     <= 1'b0;
      ack_drive   <= 1'b1;
      rx_hold     <= 8'd0;
    end else begin
      if (cfg_we)
        phase_ticks <= cfg_data;
      if (step) begin
        command_reg <= command_reg_next;
        phase_index <= phase_index_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        delay_count <= delay_count_next;
        scl_reg     <= scl_reg_next;
        sda_reg     <= sda_reg_next;
        ack_reg     <= ack_reg_next;
        ack_drive   <= ack_drive_next;
        rx_hold     <= rx_hold_next;
      end
    end
  end

endmodule

[src/i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps

// I2C master bit sequencer. Each input word is one tick of the bus timing
// clock and yields exactly one result word: the SCL/SDA drive levels, busy,
// done, the last received byte, the last sampled acknowledge and a flag for a
// command that came in while busy. A word passes an input register, one pass
// of the sequencer logic and an output register; one word per cycle is
// sustained as long as the output side does not stall. The phase length
// register (phase_ticks, reset 11) is written through the cfg channel, which
// is always ready; write it only while the block is idle.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] tx_byte,
  input  logic       ack_level,
  input  logic       sda_in,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_seen,
  output logic       rejected,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import i2cmbs_pkg::*;

  logic    in_reg_valid;
  item_t   in_reg;
  logic    step;
  result_t core_res;
  result_t out_reg;

  assign step      = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall  = in_reg_valid && !step;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= '{action: action, tx_byte: tx_byte, ack_level: ack_level, sda_in: sda_in};
    end
  end

  i2cmbs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_reg),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= core_res;
    end
  end

  assign scl_level = out_reg.scl_level;
  assign sda_level = out_reg.sda_level;
  assign busy_res  = out_reg.busy_res;
  assign done_res  = out_reg.done_res;
  assign rx_byte   = out_reg.rx_byte;
  assign ack_seen  = out_reg.ack_seen;
  assign rejected  = out_reg.rejected;

  // Checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy in the same result word");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled without a blocked word");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_reg_valid)
    else $error("accepted word not held in input register");

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed word missing at output");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import i2cmbs_pkg::*;

  localparam logic [2:0] ACT_TICK  = CMD_IDLE;
  localparam logic [2:0] ACT_SPARE = 3'd7;
  localparam int unsigned IDLE_PCT     = 27;
  localparam int unsigned STUCK_LIMIT  = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;

  localparam result_t IDLE_AFTER_RESET = '{scl_level: 1'b1, sda_level: 1'b1,
                                           busy_res: 1'b0, done_res: 1'b0,
                                           rx_byte: 8'h00, ack_seen: 1'b0,
                                           rejected: 1'b0};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] action = ACT_TICK;
  logic [7:0] tx_byte = 8'h00;
  logic       ack_level = 1'b0;
  logic       sda_in = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       rejected;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  i2c_master_bit_sequencer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .tx_byte(tx_byte), .ack_level(ack_level), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_level(scl_level), .sda_level(sda_level), .busy_res(busy_res),
    .done_res(done_res), .rx_byte(rx_byte), .ack_seen(ack_seen), .rejected(rejected),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sequencer mirror: state and phase length register
  logic [7:0] hold_ticks    = PHASE_TICKS_RESET;
  logic [2:0] seq_cmd       = CMD_IDLE;
  logic [1:0] seq_phase     = 2'd0;
  logic [3:0] seq_bits      = 4'd0;
  logic [7:0] seq_shift     = 8'h00;
  logic [7:0] seq_timer     = 8'h00;
  logic       seq_scl       = 1'b1;
  logic       seq_sda       = 1'b1;
  logic       seq_ack       = 1'b0;
  logic       seq_ack_drive = 1'b1;
  logic [7:0] seq_rx        = 8'h00;

  result_t line_words[$];   // expected result words, oldest first
  int unsigned errors = 0;
  bit calm = 1'b0;          // no gaps and no stalls while set

  // Set the bus lines for the phase being entered and reload the timer
  function automatic void enter_bus_phase();
    case (seq_cmd)
      CMD_START: begin
        if (seq_phase == 2'd0) begin
          seq_sda = 1'b1;
          seq_scl = 1'b1;
        end else seq_sda = 1'b0;
      end
      CMD_STOP: begin
        if (seq_phase == 2'd0) begin
          seq_sda = 1'b0;
          seq_scl = 1'b1;
        end else seq_sda = 1'b1;
      end
      CMD_SEND: begin
        if (seq_phase == 2'd0) seq_scl = 1'b0;
        else if (seq_phase == 2'd1) seq_sda = seq_shift[7];
        else seq_scl = 1'b1;
      end
      CMD_RECV: seq_scl = (seq_phase == 2'd0);
      CMD_WACK: begin
        if (seq_phase == 2'd0) begin
          seq_sda = 1'b1;
          seq_scl = 1'b1;
        end else seq_scl = 1'b0;
      end
      CMD_SACK: begin
        if (seq_phase == 2'd0) begin
          seq_scl = 1'b0;
          seq_sda = seq_ack_drive;
        end else if (seq_phase == 2'd1) seq_scl = 1'b1;
        else begin
          seq_scl = 1'b0;
          seq_sda = 1'b1;
        end
      end
      default: ;
    endcase
    seq_timer = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
  endfunction

  // Close the current phase; returns 1 when the command is complete
  function automatic bit close_bus_phase(input logic sda);
    logic [1:0] last_phase;
    bit         byte_cmd;
    last_phase = (seq_cmd == CMD_SEND || seq_cmd == CMD_SACK) ? 2'd2 : 2'd1;
    byte_cmd = (seq_cmd == CMD_SEND || seq_cmd == CMD_RECV);
    if (seq_cmd == CMD_RECV && seq_phase == 2'd0) seq_shift = {seq_shift[6:0], sda};
    if (seq_cmd == CMD_WACK && seq_phase == 2'd0) seq_ack = sda;
    if (seq_phase < last_phase) begin
      seq_phase = seq_phase + 2'd1;
      enter_bus_phase();
      return 1'b0;
    end
    if (byte_cmd) begin
      if (seq_cmd == CMD_SEND) seq_shift = seq_shift << 1;
      seq_bits = seq_bits + 4'd1;
      if (seq_bits < BITS_PER_BYTE) begin
        seq_phase = 2'd0;
        enter_bus_phase();
        return 1'b0;
      end
    end
    if (seq_cmd == CMD_START || seq_cmd == CMD_SEND) seq_scl = 1'b0;
    if (seq_cmd == CMD_RECV) seq_rx = seq_shift;
    seq_cmd = CMD_IDLE;
    seq_phase = 2'd0;
    seq_bits = 4'd0;
    seq_timer = 8'd0;
    return 1'b1;
  endfunction

  // One tick of the sequencer: returns the line word it produces
  function automatic result_t bus_tick(input item_t w);
    result_t r;
    bit      is_cmd;
    r = '0;
    is_cmd = (w.action >= CMD_START && w.action <= CMD_SACK);
    if (seq_cmd != CMD_IDLE) begin
      r.rejected = is_cmd;
      seq_timer = seq_timer - 8'd1;
      if (seq_timer == 8'd0) r.done_res = close_bus_phase(w.sda_in);
    end else if (is_cmd) begin
      seq_cmd = w.action;
      seq_phase = 2'd0;
      seq_bits = 4'd0;
      if (w.action == CMD_SEND) seq_shift = w.tx_byte;
      if (w.action == CMD_RECV) begin
        seq_shift = 8'h00;
        seq_sda = 1'b1;
      end
      if (w.action == CMD_SACK) seq_ack_drive = w.ack_level;
      enter_bus_phase();
    end
    r.scl_level = seq_scl;
    r.sda_level = seq_sda;
    r.busy_res  = (seq_cmd != CMD_IDLE);
    r.rx_byte   = seq_rx;
    r.ack_seen  = seq_ack;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Send one word; expectation is the typed one or the mirror's
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    action    = w.action;
    tx_byte   = w.tx_byte;
    ack_level = w.ack_level;
    sda_in    = w.sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = bus_tick(w);
    line_words.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic send_tick();
    item_t w;
    w.action    = ACT_TICK;
    w.tx_byte   = 8'($urandom_range(0, 255));
    w.ack_level = 1'($urandom_range(0, 1));
    w.sda_in    = 1'($urandom_range(0, 1));
    send_word(w, 1'b0, '0);
  endtask

  // Finish the running command, drain results, then let the pipe empty
  task automatic settle();
    while (seq_cmd != CMD_IDLE) send_tick();
    in_valid = 1'b0;
    while (line_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_phase_ticks(input logic [7:0] v);
    settle();
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hold_ticks = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly clean command streams; some commands while busy and spare codes
  function automatic item_t pick_word();
    item_t       w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    w.tx_byte   = 8'($urandom_range(0, 255));
    w.ack_level = 1'($urandom_range(0, 1));
    w.sda_in    = 1'($urandom_range(0, 1));
    if (seq_cmd == CMD_IDLE)
      w.action = (roll < 75) ? 3'($urandom_range(CMD_START, CMD_SACK)) :
                 (roll < 88) ? ACT_TICK : ACT_SPARE;
    else
      w.action = (roll < 6) ? 3'($urandom_range(CMD_START, CMD_SACK)) :
                 (roll < 10) ? ACT_SPARE : ACT_TICK;
    return w;
  endfunction

  // Directed stimulus table
  typedef struct {
    bit          set_cfg;
    logic [7:0]  cfg_value;
    item_t       w;
    int unsigned reps;
    bit          typed;
    result_t     want;
  } plan_row_t;

  plan_row_t plan[$];

  task automatic add_row(input bit set_cfg, input logic [7:0] cfg_value,
                         input logic [2:0] act, input logic [7:0] tx, input logic ack,
                         input logic sda, input int unsigned reps, input bit typed);
    plan_row_t r;
    r.set_cfg     = set_cfg;
    r.cfg_value   = cfg_value;
    r.w.action    = act;
    r.w.tx_byte   = tx;
    r.w.ack_level = ack;
    r.w.sda_in    = sda;
    r.reps        = reps;
    r.typed       = typed;
    r.want        = IDLE_AFTER_RESET;
    plan.push_back(r);
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {scl_level, sda_level, busy_res, done_res, rx_byte, ack_seen, rejected};
      if (line_words.size() == 0) begin
        note_failure($sformatf("result word %h with nothing expected", got));
      end else begin
        want = line_words.pop_front();
        if (got.scl_level !== want.scl_level)
          note_failure($sformatf("scl_level %b, want %b", got.scl_level, want.scl_level));
        if (got.sda_level !== want.sda_level)
          note_failure($sformatf("sda_level %b, want %b", got.sda_level, want.sda_level));
        if (got.busy_res !== want.busy_res)
          note_failure($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          note_failure($sformatf("done_res %b, want %b", got.done_res, want.done_res));
        if (got.rx_byte !== want.rx_byte)
          note_failure($sformatf("rx_byte %h, want %h", got.rx_byte, want.rx_byte));
        if (got.ack_seen !== want.ack_seen)
          note_failure($sformatf("ack_seen %b, want %b", got.ack_seen, want.ack_seen));
        if (got.rejected !== want.rejected)
          note_failure($sformatf("rejected %b, want %b", got.rejected, want.rejected));
      end
    end
  end

  // Output backpressure
  always @(negedge clk) out_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);

  // Watchdog: cycles with no handshake on any channel
  int unsigned stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("** i2c_master_bit_sequencer: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [7:0]  sweep[8];
    int unsigned phase_words;
    int unsigned rand_words;
    sweep = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd3, 8'd6, 8'd4, 8'd1};
    sweep[7] = 8'($urandom_range(1, 16));
    rand_words = 0;

    // idle rows at reset length, then one start at the reset length
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 1, 1);
    add_row(0, 0, ACT_SPARE, 8'hFF, 1, 1, 1, 1);
    add_row(0, 0, CMD_START, 8'hFF, 1, 1, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 22, 0);
    // shortest phases: every command, byte extremes
    add_row(1, 8'd1, CMD_STOP, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 1, 2, 0);
    add_row(0, 0, CMD_SEND, 8'hFF, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 24, 0);
    add_row(0, 0, CMD_SEND, 8'h00, 1, 1, 1, 0);
    // command while busy is dropped and flagged
    add_row(0, 0, CMD_STOP, 8'hFF, 1, 1, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 23, 0);
    add_row(0, 0, CMD_RECV, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 1, 16, 0);
    add_row(0, 0, CMD_RECV, 8'hFF, 1, 1, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 16, 0);
    add_row(0, 0, CMD_WACK, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 2, 0);
    add_row(0, 0, CMD_WACK, 8'h00, 0, 1, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 1, 2, 0);
    add_row(0, 0, CMD_SACK, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 3, 0);
    add_row(0, 0, CMD_SACK, 8'h00, 1, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 3, 0);
    // command landing on the finishing tick
    add_row(0, 0, CMD_START, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, CMD_START, 8'h00, 0, 0, 1, 0);
    // zero length behaves as one tick
    add_row(1, 8'd0, CMD_START, 8'h00, 0, 0, 1, 0);
    add_row(0, 0, ACT_TICK, 8'h00, 0, 0, 2, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].set_cfg) write_phase_ticks(plan[i].cfg_value);
      repeat (plan[i].reps) send_word(plan[i].w, plan[i].typed, plan[i].want);
    end

    // random words over a sweep of phase lengths
    foreach (sweep[k]) begin
      write_phase_ticks(sweep[k]);
      phase_words = (sweep[k] == 8'd255) ? 120 : 150;
      repeat (phase_words) begin
        calm = (rand_words >= 300 && rand_words < 550);
        send_word(pick_word(), 1'b0, '0);
        rand_words++;
      end
      calm = 1'b0;
    end

    settle();
    if (errors == 0)
      $display("** i2c_master_bit_sequencer: PASSED **");
    else
      $display("** i2c_master_bit_sequencer: FAILED **");
    $finish;
  end

endmodule

[files.f]
src/i2cmbs_pkg.sv
src/i2cmbs_core.sv
src/i2c_master_bit_sequencer.sv
bench/testbench.sv
